@@ sv/obbot_pkg.sv @@
package obbot_pkg;

  localparam int TW = 16;
  localparam int XW = 33;
  localparam int ZW = 25;
  localparam int CORDIC_STG = 4;
  localparam int CORDIC_PER_STG = 4;
  localparam int CORDIC_LAT = CORDIC_STG + 1;
  localparam int UW = 2 * TW + 1;
  localparam int NAX = 4;

  localparam logic signed [XW-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [XW-1:0] RND_HALF = 33'sd32768;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic signed [TW-1:0] trig_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 25'sd2097152;
      1: a = 25'sd1238021;
      2: a = 25'sd654136;
      3: a = 25'sd332050;
      4: a = 25'sd166669;
      5: a = 25'sd83416;
      6: a = 25'sd41718;
      7: a = 25'sd20860;
      8: a = 25'sd10430;
      9: a = 25'sd5215;
      10: a = 25'sd2608;
      11: a = 25'sd1304;
      12: a = 25'sd652;
      13: a = 25'sd326;
      14: a = 25'sd163;
      15: a = 25'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ sv/obb_overlap_test.sv @@
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | in_obs_*, in_oth_* (two boxes)
// out     | out_valid | out_ready | out_hit
//
// nine register stages: five for cosine and sine, four for projection and compare
// one item per cycle sustained while out_ready is high
// rst_n is synchronous and clears the stage valid bits only
// a held result stalls every stage together; in_ready is low only while stalled

module obb_overlap_test
  import obbot_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_obs_center_x,
  input  logic signed [COORD_BITS-1:0] in_obs_center_y,
  input  logic [COORD_BITS-3:0]        in_obs_half_w,
  input  logic [COORD_BITS-3:0]        in_obs_half_h,
  input  logic [ANGLE_BITS-1:0]        in_obs_angle,
  input  logic signed [COORD_BITS-1:0] in_oth_center_x,
  input  logic signed [COORD_BITS-1:0] in_oth_center_y,
  input  logic [COORD_BITS-3:0]        in_oth_half_w,
  input  logic [COORD_BITS-3:0]        in_oth_half_h,
  input  logic [ANGLE_BITS-1:0]        in_oth_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);

  localparam int CW   = COORD_BITS;
  localparam int HW   = COORD_BITS - 2;
  localparam int NSTG = CORDIC_LAT + 4;
  localparam int DPW  = CW + 1 + TW;
  localparam int DSW  = DPW + 1;
  localparam int DAW  = DSW + 14;
  localparam int RPW  = HW + UW;
  localparam int RSW  = RPW + 2;
  localparam int CMPW = (DAW > RSW) ? DAW : RSW;

  logic            en;
  logic [NSTG-1:0] vld_r;

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  trig_t ca, sa, cb, sb;

  obbot_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_trig_a (
    .clk(clk), .en(en), .angle_i(in_obs_angle), .cos_o(ca), .sin_o(sa)
  );

  obbot_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_trig_b (
    .clk(clk), .en(en), .angle_i(in_oth_angle), .cos_o(cb), .sin_o(sb)
  );

  // payload delay line alongside the trig pipeline
  logic signed [CW:0] dx_r [CORDIC_LAT];
  logic signed [CW:0] dy_r [CORDIC_LAT];
  logic [HW-1:0]      wa_r [CORDIC_LAT];
  logic [HW-1:0]      ha_r [CORDIC_LAT];
  logic [HW-1:0]      wb_r [CORDIC_LAT];
  logic [HW-1:0]      hb_r [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= (CW+1)'(in_obs_center_x) - (CW+1)'(in_oth_center_x);
      dy_r[0] <= (CW+1)'(in_obs_center_y) - (CW+1)'(in_oth_center_y);
      wa_r[0] <= in_obs_half_w;
      ha_r[0] <= in_obs_half_h;
      wb_r[0] <= in_oth_half_w;
      hb_r[0] <= in_oth_half_h;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
        wa_r[i] <= wa_r[i-1];
        ha_r[i] <= ha_r[i-1];
        wb_r[i] <= wb_r[i-1];
        hb_r[i] <= hb_r[i-1];
      end
    end
  end

  // axes: width and height edges of each box
  trig_t axx [NAX];
  trig_t axy [NAX];

  assign axx[0] = ca;
  assign axy[0] = sa;
  assign axx[1] = -sa;
  assign axy[1] = ca;
  assign axx[2] = cb;
  assign axy[2] = sb;
  assign axx[3] = -sb;
  assign axy[3] = cb;

  // stage m1: products
  logic signed [2*TW-1:0] pa_r [NAX][4];
  logic signed [2*TW-1:0] pb_r [NAX][4];
  logic signed [DPW-1:0]  pdx_r [NAX];
  logic signed [DPW-1:0]  pdy_r [NAX];
  logic [HW-1:0]          wa1_r, ha1_r, wb1_r, hb1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NAX; k++) begin
        pa_r[k][0] <= ca * axx[k];
        pa_r[k][1] <= sa * axy[k];
        pa_r[k][2] <= ca * axy[k];
        pa_r[k][3] <= sa * axx[k];
        pb_r[k][0] <= cb * axx[k];
        pb_r[k][1] <= sb * axy[k];
        pb_r[k][2] <= cb * axy[k];
        pb_r[k][3] <= sb * axx[k];
        pdx_r[k]   <= dx_r[CORDIC_LAT-1] * DPW'(axx[k]);
        pdy_r[k]   <= dy_r[CORDIC_LAT-1] * DPW'(axy[k]);
      end
      wa1_r <= wa_r[CORDIC_LAT-1];
      ha1_r <= ha_r[CORDIC_LAT-1];
      wb1_r <= wb_r[CORDIC_LAT-1];
      hb1_r <= hb_r[CORDIC_LAT-1];
    end
  end

  // stage m2: dot products and magnitudes
  logic [UW-1:0]         ua_r [NAX];
  logic [UW-1:0]         va_r [NAX];
  logic [UW-1:0]         ub_r [NAX];
  logic [UW-1:0]         vb_r [NAX];
  logic signed [DSW-1:0] ds_r [NAX];
  logic [HW-1:0]         wa2_r, ha2_r, wb2_r, hb2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NAX; k++) begin
        logic signed [UW-1:0] t0, t1, t2, t3;
        t0 = UW'(pa_r[k][0]) + UW'(pa_r[k][1]);
        t1 = UW'(pa_r[k][2]) - UW'(pa_r[k][3]);
        t2 = UW'(pb_r[k][0]) + UW'(pb_r[k][1]);
        t3 = UW'(pb_r[k][2]) - UW'(pb_r[k][3]);
        ua_r[k] <= (t0 < 0) ? UW'(-t0) : UW'(t0);
        va_r[k] <= (t1 < 0) ? UW'(-t1) : UW'(t1);
        ub_r[k] <= (t2 < 0) ? UW'(-t2) : UW'(t2);
        vb_r[k] <= (t3 < 0) ? UW'(-t3) : UW'(t3);
        ds_r[k] <= DSW'(pdx_r[k]) + DSW'(pdy_r[k]);
      end
      wa2_r <= wa1_r;
      ha2_r <= ha1_r;
      wb2_r <= wb1_r;
      hb2_r <= hb1_r;
    end
  end

  // stage m3: radii terms and centre distance
  logic [RPW-1:0] r_r [NAX][4];
  logic [DAW-1:0] da_r [NAX];
  logic [NAX-1:0] zf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NAX; k++) begin
        r_r[k][0] <= RPW'(wa2_r) * RPW'(ua_r[k]);
        r_r[k][1] <= RPW'(ha2_r) * RPW'(va_r[k]);
        r_r[k][2] <= RPW'(wb2_r) * RPW'(ub_r[k]);
        r_r[k][3] <= RPW'(hb2_r) * RPW'(vb_r[k]);
        da_r[k]   <= DAW'((ds_r[k] < 0) ? -ds_r[k] : ds_r[k]) << 14;
      end
      zf_r <= {hb2_r == '0, wb2_r == '0, ha2_r == '0, wa2_r == '0};
    end
  end

  // stage m4: interval compare on every axis, skipped where that axis's half-length is zero
  logic hit_r, hit_nxt;

  always_comb begin
    logic [RSW-1:0] rs;
    hit_nxt = 1'b1;
    for (int k = 0; k < NAX; k++) begin
      rs = RSW'(r_r[k][0]) + RSW'(r_r[k][1]) + RSW'(r_r[k][2]) + RSW'(r_r[k][3]);
      if (!zf_r[k] && (CMPW'(da_r[k]) > CMPW'(rs))) begin
        hit_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_hit = hit_r;

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("stage valids moved during a stall");

  a_zero_boxes_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[NSTG-2] && (zf_r == '1)) |=> out_hit)
    else $error("degenerate boxes must report a hit");

endmodule

@@ sv/obbot_cordic.sv @@
module obbot_cordic
  import obbot_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output trig_t                 cos_o,
  output trig_t                 sin_o
);

  logic signed [XW-1:0] x_r [CORDIC_STG];
  logic signed [XW-1:0] y_r [CORDIC_STG];
  logic signed [ZW-1:0] z_r [CORDIC_STG];
  logic [1:0]           q_r [CORDIC_STG];
  trig_t                cos_r, sin_r;
  trig_t                cos_nxt, sin_nxt;
  logic [23:0]          a24;

  assign a24 = 24'(angle_i) << (24 - ANGLE_BITS);

  for (genvar g = 0; g < CORDIC_STG; g++) begin : g_stg
    logic signed [XW-1:0] x_i, y_i, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_i, z_nxt;
    logic [1:0]           q_i;

    if (g == 0) begin : g_first
      assign x_i = CORDIC_X0;
      assign y_i = '0;
      assign z_i = ZW'(a24[21:0]);
      assign q_i = a24[23:22];
    end else begin : g_rest
      assign x_i = x_r[g-1];
      assign y_i = y_r[g-1];
      assign z_i = z_r[g-1];
      assign q_i = q_r[g-1];
    end

    always_comb begin
      logic signed [XW-1:0] xv, yv, dxv, dyv;
      logic signed [ZW-1:0] zv;
      xv = x_i;
      yv = y_i;
      zv = z_i;
      for (int j = 0; j < CORDIC_PER_STG; j++) begin
        dxv = yv >>> (g * CORDIC_PER_STG + j);
        dyv = xv >>> (g * CORDIC_PER_STG + j);
        if (zv >= 0) begin
          xv = xv - dxv;
          yv = yv + dyv;
          zv = zv - atan_turn(g * CORDIC_PER_STG + j);
        end else begin
          xv = xv + dxv;
          yv = yv - dyv;
          zv = zv + atan_turn(g * CORDIC_PER_STG + j);
        end
      end
      x_nxt = xv;
      y_nxt = yv;
      z_nxt = zv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g] <= x_nxt;
        y_r[g] <= y_nxt;
        z_r[g] <= z_nxt;
        q_r[g] <= q_i;
      end
    end
  end

  // round to q1.14 then fold in the quadrant
  always_comb begin
    logic signed [XW-1:0] xs, ys;
    trig_t                xr, yr;
    xs = x_r[CORDIC_STG-1] + RND_HALF;
    ys = y_r[CORDIC_STG-1] + RND_HALF;
    xr = xs[TW+15:16];
    yr = ys[TW+15:16];
    case (q_r[CORDIC_STG-1])
      QUAD_0: begin
        cos_nxt = xr;
        sin_nxt = yr;
      end
      QUAD_1: begin
        cos_nxt = -yr;
        sin_nxt = xr;
      end
      QUAD_2: begin
        cos_nxt = -xr;
        sin_nxt = -yr;
      end
      default: begin
        cos_nxt = yr;
        sin_nxt = -xr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
